// ===== rtl/ldrs_pkg.sv =====
// ----------------------------------------------------------------------------
// ldrs_pkg
// Shared types and constants of the look-ahead disk request scheduler.
// ----------------------------------------------------------------------------
package ldrs_pkg;

  localparam int DEF_QUEUE_DEPTH   = 1024;
  localparam int DEF_LA_COUNT      = 128;
  localparam int DEF_LA_SIZE       = 65536;
  localparam int DEF_SEEK_BACK     = 8388608;

  localparam int ADDR_W   = 48;
  localparam int SIZE_W   = 32;
  localparam int TAG_W    = 16;
  localparam int LACNT_W  = 11;
  localparam int STATUS_W = 3;
  localparam int CFGIDX_W = 2;

  // one queue entry as it sits in the entry memory
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
    logic              wr;
    logic              reorder;
    logic [TAG_W-1:0]  tag;
    logic              retired;
  } entry_t;

  typedef struct packed {
    logic [LACNT_W-1:0] la_count;
    logic [SIZE_W-1:0]  la_size;
    logic [SIZE_W-1:0]  seek_back;
  } cfg_t;

  // verdict on one scanned entry
  typedef struct packed {
    logic stop;
    logic take;
  } pick_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_ENQ    = 3'd0,
    STAT_FULL   = 3'd1,
    STAT_ISSUED = 3'd2,
    STAT_EMPTY  = 3'd3,
    STAT_SKIP   = 3'd4
  } status_t;

  typedef enum logic [CFGIDX_W-1:0] {
    CFG_LA_COUNT  = 2'd0,
    CFG_LA_SIZE   = 2'd1,
    CFG_SEEK_BACK = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HEAD,
    ST_SCAN,
    ST_DONE
  } state_t;

  localparam logic OP_ENQ = 1'b0;

endpackage

// ===== rtl/ldrs_ram.sv =====
// ----------------------------------------------------------------------------
// ldrs_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ldrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/ldrs_pick.sv =====
// ----------------------------------------------------------------------------
// ldrs_pick
// Judges one scanned entry: stop the scan, or take it as the new target.
// ----------------------------------------------------------------------------
module ldrs_pick (
  input  ldrs_pkg::entry_t                 rec,
  input  logic [ldrs_pkg::ADDR_W-1:0]      target,
  input  logic [ldrs_pkg::ADDR_W-1:0]      base,
  input  logic [ldrs_pkg::ADDR_W-1:0]      head_loc,
  input  logic                             fwd,
  input  ldrs_pkg::cfg_t                   cfg,
  output ldrs_pkg::pick_t                  verdict
);
  import ldrs_pkg::*;

  logic              skip;
  logic              near;
  logic [ADDR_W-1:0] back_dist;

  assign back_dist = base - rec.addr;
  assign skip      = rec.retired || (rec.size > cfg.la_size);

  always_comb begin
    if (fwd) begin
      near = (rec.addr > head_loc) && (rec.addr < target);
    end else begin
      near = (rec.addr < target) && (back_dist < ADDR_W'(cfg.seek_back));
    end
  end

  // an unreorderable write fences everything behind it
  assign verdict.stop = rec.wr && !rec.reorder;
  assign verdict.take = !verdict.stop && !skip && near;

endmodule

// ===== rtl/ldrs_ctrl.sv =====
// ----------------------------------------------------------------------------
// ldrs_ctrl
// Ring pointers, scan sequencer and result register around the entry memory.
// ----------------------------------------------------------------------------
module ldrs_ctrl #(
  parameter int QUEUE_DEPTH = ldrs_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             op,
  input  logic                             is_write,
  input  logic                             reorder_ok,
  input  logic [ldrs_pkg::ADDR_W-1:0]      file_base,
  input  logic [ldrs_pkg::ADDR_W-1:0]      file_offset,
  input  logic [ldrs_pkg::SIZE_W-1:0]      size,
  input  logic [ldrs_pkg::TAG_W-1:0]       request_tag,
  input  ldrs_pkg::cfg_t                   cfg,
  output logic                             ram_we,
  output logic [$clog2(QUEUE_DEPTH)-1:0]   ram_waddr,
  output ldrs_pkg::entry_t                 ram_wdata,
  output logic [$clog2(QUEUE_DEPTH)-1:0]   ram_raddr,
  input  ldrs_pkg::entry_t                 ram_rdata,
  output logic                             done,
  output logic [ldrs_pkg::STATUS_W-1:0]    status,
  output logic [$clog2(QUEUE_DEPTH)-1:0]   slot,
  output logic [ldrs_pkg::ADDR_W-1:0]      issue_addr,
  output logic [ldrs_pkg::SIZE_W-1:0]      issue_size,
  output logic                             issue_write,
  output logic [ldrs_pkg::TAG_W-1:0]       issue_tag,
  output logic                             from_lookahead
);
  import ldrs_pkg::*;

  localparam int SW = $clog2(QUEUE_DEPTH);
  localparam int IW = $clog2(2 * QUEUE_DEPTH);
  localparam int NW = IW + 1;
  localparam int CW = (NW > LACNT_W) ? NW : LACNT_W;
  localparam logic [IW-1:0] DEPTH_I = IW'(QUEUE_DEPTH);
  localparam logic [IW-1:0] LAST_I  = IW'(2 * QUEUE_DEPTH - 1);
  localparam logic [NW-1:0] SPAN_N  = NW'(2 * QUEUE_DEPTH);
  localparam logic [NW-1:0] DEPTH_N = NW'(QUEUE_DEPTH);

  function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] p);
    ring_next = (p == LAST_I) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [SW-1:0] slot_of(input logic [IW-1:0] p);
    slot_of = (p >= DEPTH_I) ? SW'(p - DEPTH_I) : SW'(p);
  endfunction

  state_t             state, state_next;
  logic [IW-1:0]      head_idx, head_idx_next;
  logic [IW-1:0]      tail_idx, tail_idx_next;
  logic [ADDR_W-1:0]  head_loc, head_loc_next;
  logic [ADDR_W-1:0]  target, target_next;
  logic [ADDR_W-1:0]  base, base_next;
  logic               fwd, fwd_next;
  logic               la, la_next;
  logic [SW-1:0]      chosen_slot, chosen_slot_next;
  entry_t             chosen_rec, chosen_rec_next;
  logic [IW-1:0]      rd_ptr, rd_ptr_next;
  logic [CW-1:0]      rd_left, rd_left_next;
  logic               pend, pend_next;
  logic [SW-1:0]      ev_slot, ev_slot_next;

  logic               done_next;
  status_t            status_next;
  logic [SW-1:0]      slot_next;
  entry_t             res_rec_next;
  logic               res_la_next;

  logic [NW-1:0]      count;
  logic [CW-1:0]      scan_len;
  logic [CW-1:0]      scan_more;
  logic [IW-1:0]      first_ptr;
  pick_t              verdict;
  entry_t             enq_rec;

  always_comb begin
    count = {1'b0, tail_idx} - {1'b0, head_idx};
    if (tail_idx < head_idx) begin
      count = count + SPAN_N;
    end
  end

  // scan window from the head (scan_len) and entries behind the head the scan may look at (scan_more)
  assign scan_len  = (CW'(cfg.la_count) < CW'(count)) ? CW'(cfg.la_count) : CW'(count);
  assign scan_more = (scan_len != '0) ? scan_len - 1'b1 : '0;
  assign first_ptr = ring_next(head_idx);

  always_comb begin
    enq_rec         = '0;
    enq_rec.addr    = file_base + file_offset;
    enq_rec.size    = size;
    enq_rec.wr      = is_write;
    enq_rec.reorder = reorder_ok;
    enq_rec.tag     = request_tag;
    enq_rec.retired = 1'b0;
  end

  ldrs_pick u_pick (
    .rec      (ram_rdata),
    .target   (target),
    .base     (base),
    .head_loc (head_loc),
    .fwd      (fwd),
    .cfg      (cfg),
    .verdict  (verdict)
  );

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      head_idx <= '0;
      tail_idx <= '0;
      head_loc <= '0;
      pend     <= 1'b0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      head_idx <= head_idx_next;
      tail_idx <= tail_idx_next;
      head_loc <= head_loc_next;
      pend     <= pend_next;
      done     <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    target         <= target_next;
    base           <= base_next;
    fwd            <= fwd_next;
    la             <= la_next;
    chosen_slot    <= chosen_slot_next;
    chosen_rec     <= chosen_rec_next;
    rd_ptr         <= rd_ptr_next;
    rd_left        <= rd_left_next;
    ev_slot        <= ev_slot_next;
    status         <= status_next;
    slot           <= slot_next;
    issue_addr     <= res_rec_next.addr;
    issue_size     <= res_rec_next.size;
    issue_write    <= res_rec_next.wr;
    issue_tag      <= res_rec_next.tag;
    from_lookahead <= res_la_next;
  end

  always_comb begin
    state_next       = state;
    head_idx_next    = head_idx;
    tail_idx_next    = tail_idx;
    head_loc_next    = head_loc;
    target_next      = target;
    base_next        = base;
    fwd_next         = fwd;
    la_next          = la;
    chosen_slot_next = chosen_slot;
    chosen_rec_next  = chosen_rec;
    rd_ptr_next      = rd_ptr;
    rd_left_next     = rd_left;
    pend_next        = pend;
    ev_slot_next     = ev_slot;
    done_next        = 1'b0;
    status_next      = STAT_ENQ;
    slot_next        = '0;
    res_rec_next     = '0;
    res_la_next      = 1'b0;
    ram_we           = 1'b0;
    ram_waddr        = slot_of(tail_idx);
    ram_wdata        = enq_rec;
    ram_raddr        = slot_of(head_idx);

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          done_next = 1'b1;
          if (op == OP_ENQ) begin
            slot_next = slot_of(tail_idx);
            if (count >= DEPTH_N) begin
              status_next = STAT_FULL;
            end else begin
              status_next   = STAT_ENQ;
              ram_we        = 1'b1;
              tail_idx_next = ring_next(tail_idx);
            end
          end else if (count == '0) begin
            status_next = STAT_EMPTY;
          end else begin
            // head entry read is in flight, result comes later
            done_next  = 1'b0;
            state_next = ST_HEAD;
          end
        end
      end

      ST_HEAD: begin
        if (ram_rdata.retired) begin
          ram_we            = 1'b1;
          ram_waddr         = slot_of(head_idx);
          ram_wdata         = ram_rdata;
          ram_wdata.retired = 1'b0;
          head_idx_next     = ring_next(head_idx);
          done_next         = 1'b1;
          status_next       = STAT_SKIP;
          slot_next         = slot_of(head_idx);
          state_next        = ST_IDLE;
        end else begin
          target_next      = ram_rdata.addr;
          base_next        = ram_rdata.addr;
          fwd_next         = (ram_rdata.addr >= head_loc);
          la_next          = 1'b0;
          chosen_slot_next = slot_of(head_idx);
          chosen_rec_next  = ram_rdata;
          ram_raddr        = slot_of(first_ptr);
          ev_slot_next     = slot_of(first_ptr);
          rd_ptr_next      = ring_next(first_ptr);
          pend_next        = (scan_more != '0);
          rd_left_next     = (scan_more != '0) ? scan_more - 1'b1 : '0;
          state_next       = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (!pend) begin
          state_next = ST_DONE;
        end else if (verdict.stop) begin
          pend_next  = 1'b0;
          state_next = ST_DONE;
        end else begin
          if (verdict.take) begin
            target_next      = ram_rdata.addr;
            chosen_slot_next = ev_slot;
            chosen_rec_next  = ram_rdata;
            la_next          = 1'b1;
          end
          // one read issued per cycle, evaluated the next
          ram_raddr = slot_of(rd_ptr);
          if (rd_left != '0) begin
            ev_slot_next = slot_of(rd_ptr);
            rd_ptr_next  = ring_next(rd_ptr);
            rd_left_next = rd_left - 1'b1;
            pend_next    = 1'b1;
          end else begin
            pend_next = 1'b0;
          end
        end
      end

      ST_DONE: begin
        head_loc_next = target;
        if (la) begin
          ram_we            = 1'b1;
          ram_waddr         = chosen_slot;
          ram_wdata         = chosen_rec;
          ram_wdata.retired = 1'b1;
        end else begin
          head_idx_next = ring_next(head_idx);
        end
        done_next    = 1'b1;
        status_next  = STAT_ISSUED;
        slot_next    = chosen_slot;
        res_rec_next = chosen_rec;
        res_la_next  = la;
        state_next   = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/lookahead_disk_request_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// lookahead_disk_request_scheduler_unit
// Ring queue of disk requests with a look-ahead elevator pick on schedule.
//
//   channel   handshake              payload
//   command   start / busy           op, is_write, reorder_ok, file_base,
//                                    file_offset, size, request_tag
//   result    done (one-cycle beat)  status, slot, issue_addr, issue_size,
//                                    issue_write, issue_tag, from_lookahead
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// enqueue, full and empty beats come the cycle after the command, busy stays low
// skipped head: busy in ST_HEAD only; issue: busy in ST_HEAD, ST_SCAN and ST_DONE,
//   scanning n entries behind the head, bounded by look-ahead count and queue fill
// the result beat comes in the same cycle that busy drops
// scan rate is one entry memory read per cycle
// rst is synchronous; entry memory is not cleared, only ring pointers, control and config
// results cannot be held off: each beat lasts exactly one cycle
// ----------------------------------------------------------------------------
module lookahead_disk_request_scheduler_unit #(
  parameter int QUEUE_DEPTH = ldrs_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             op,
  input  logic                             is_write,
  input  logic                             reorder_ok,
  input  logic [ldrs_pkg::ADDR_W-1:0]      file_base,
  input  logic [ldrs_pkg::ADDR_W-1:0]      file_offset,
  input  logic [ldrs_pkg::SIZE_W-1:0]      size,
  input  logic [ldrs_pkg::TAG_W-1:0]       request_tag,
  output logic                             done,
  output logic [ldrs_pkg::STATUS_W-1:0]    status,
  output logic [$clog2(QUEUE_DEPTH)-1:0]   slot,
  output logic [ldrs_pkg::ADDR_W-1:0]      issue_addr,
  output logic [ldrs_pkg::SIZE_W-1:0]      issue_size,
  output logic                             issue_write,
  output logic [ldrs_pkg::TAG_W-1:0]       issue_tag,
  output logic                             from_lookahead,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ldrs_pkg::CFGIDX_W-1:0]    cfg_index,
  input  logic [ldrs_pkg::SIZE_W-1:0]      cfg_data
);
  import ldrs_pkg::*;

  localparam int SW = $clog2(QUEUE_DEPTH);

  cfg_t          cfg;
  logic          ram_we;
  logic [SW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [SW-1:0] ram_raddr;
  entry_t        ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.la_count  <= LACNT_W'(DEF_LA_COUNT);
      cfg.la_size   <= SIZE_W'(DEF_LA_SIZE);
      cfg.seek_back <= SIZE_W'(DEF_SEEK_BACK);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LA_COUNT:  cfg.la_count  <= cfg_data[LACNT_W-1:0];
        CFG_LA_SIZE:   cfg.la_size   <= cfg_data;
        CFG_SEEK_BACK: cfg.seek_back <= cfg_data;
        CFG_UNUSED:    ;
      endcase
    end
  end

  ldrs_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ldrs_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .op             (op),
    .is_write       (is_write),
    .reorder_ok     (reorder_ok),
    .file_base      (file_base),
    .file_offset    (file_offset),
    .size           (size),
    .request_tag    (request_tag),
    .cfg            (cfg),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .done           (done),
    .status         (status),
    .slot           (slot),
    .issue_addr     (issue_addr),
    .issue_size     (issue_size),
    .issue_write    (issue_write),
    .issue_tag      (issue_tag),
    .from_lookahead (from_lookahead)
  );

endmodule
